// ===== hw/rtl/wetc_pkg.sv =====
// Shared types and constants for the wheel encoder tick counter.
package wetc_pkg;

  // Input item: edge event or register read request
  typedef struct packed {
    logic       func;
    logic [1:0] channel;
    logic       partner_level;
    logic [7:0] reg_addr;
  } req_item_t;

  // Result item: one byte of a read response
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rsp_item_t;

  typedef enum logic [1:0] {
    MODE_TWO_WIRE_LOW  = 2'd0,
    MODE_TWO_WIRE_HIGH = 2'd1,
    MODE_FOUR_WIRE     = 2'd2,
    MODE_QUADRATURE    = 2'd3
  } count_mode_t;

  // Commands passed from front to back
  typedef enum logic [2:0] {
    CMD_COUNT_UP,
    CMD_COUNT_DOWN,
    CMD_READ_ID,
    CMD_READ_COUNTERS,
    CMD_READ_PPR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [1:0] idx;
  } cmd_t;

  // Configuration values the back end reports
  typedef struct packed {
    logic signed [15:0] pulses_per_rev;
    logic [7:0]         unit_id;
  } report_cfg_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_COUNT_MODE = 2'd0;
  localparam logic [1:0] CFG_PPR        = 2'd1;
  localparam logic [1:0] CFG_UNIT_ID    = 2'd2;

  localparam count_mode_t        RESET_MODE = MODE_FOUR_WIRE;
  localparam logic signed [15:0] RESET_PPR  = 16'sd2;
  localparam logic [7:0]         RESET_ID   = 8'd78;  // 'N'

  // Function codes
  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Register map
  localparam logic [7:0] REG_ID        = 8'd0;
  localparam logic [7:0] REG_CNT_FIRST = 8'd1;
  localparam logic [7:0] REG_CNT_LAST  = 8'd4;
  localparam logic [7:0] REG_PPR       = 8'd5;

  // Counter block layout: four count bytes then two speed bytes
  localparam logic [2:0] BLOCK_LAST_POS = 3'd5;
  localparam logic [1:0] LAST_COUNTER   = 2'd3;
  localparam int         REPORT_WIDTH   = 32;

  // Command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

// ===== hw/rtl/wetc_front.sv =====
// Front end: accepts input items and turns them into back-end commands.
module wetc_front (
  input  logic                req_valid,
  output logic                req_ready,
  input  wetc_pkg::req_item_t req,
  input  wetc_pkg::count_mode_t count_mode,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output wetc_pkg::cmd_t      cmd
);
  import wetc_pkg::*;

  logic keep;
  logic quad;

  assign quad = (count_mode == MODE_QUADRATURE);

  // Classify: items that change nothing and emit nothing are dropped here
  always_comb begin
    keep    = 1'b0;
    cmd.op  = CMD_COUNT_UP;
    cmd.idx = req.channel;
    if (req.func == FUNC_EDGE) begin
      if (!req.channel[1]) begin
        keep   = 1'b1;
        cmd.op = (quad && !req.partner_level) ? CMD_COUNT_DOWN : CMD_COUNT_UP;
      end else if (!quad) begin
        keep = 1'b1;
      end
    end else begin
      if (req.reg_addr == REG_ID) begin
        keep   = 1'b1;
        cmd.op = CMD_READ_ID;
      end else if (req.reg_addr <= REG_CNT_LAST) begin
        keep    = 1'b1;
        cmd.op  = CMD_READ_COUNTERS;
        cmd.idx = 2'(req.reg_addr - REG_CNT_FIRST);
      end else if (req.reg_addr == REG_PPR) begin
        keep   = 1'b1;
        cmd.op = CMD_READ_PPR;
      end
    end
  end

  // Dropped items still wait for queue room so ordering stays simple
  assign req_ready = cmd_ready;
  assign cmd_valid = req_valid && keep;

endmodule

// ===== hw/rtl/wetc_queue.sv =====
// Short command queue between the front and back ends.
module wetc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  wetc_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output wetc_pkg::cmd_t pop_data
);
  import wetc_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

// ===== hw/rtl/wetc_back.sv =====
// Back end: tick counters and the byte-serial read response streamer.
module wetc_back #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  wetc_pkg::cmd_t        cmd,
  input  wetc_pkg::report_cfg_t cfg,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output wetc_pkg::rsp_item_t   rsp
);
  import wetc_pkg::*;

  logic [3:0][COUNT_WIDTH-1:0] counts;
  logic                        rd_active;
  cmd_op_t                     rd_op;
  logic [1:0]                  rd_idx;
  logic [2:0]                  rd_pos;

  logic                        cmd_pop;
  logic                        emit;
  logic [REPORT_WIDTH-1:0]     cur_word;
  logic [7:0]                  byte_val;
  logic                        byte_last;

  assign cmd_ready = !rd_active;
  assign cmd_pop   = cmd_valid && cmd_ready;
  assign emit      = rd_active && (!rsp_valid || rsp_ready);

  // Selected counter, sign-extended to the reported width
  assign cur_word = REPORT_WIDTH'($signed(counts[rd_idx]));

  // Next response byte
  always_comb begin
    byte_val  = 8'd0;
    byte_last = 1'b0;
    case (rd_op)
      CMD_READ_ID: begin
        byte_val  = cfg.unit_id;
        byte_last = 1'b1;
      end
      CMD_READ_PPR: begin
        byte_val  = rd_pos[0] ? cfg.pulses_per_rev[7:0] : cfg.pulses_per_rev[15:8];
        byte_last = rd_pos[0];
      end
      CMD_READ_COUNTERS: begin
        case (rd_pos)
          3'd0:    byte_val = cur_word[31:24];
          3'd1:    byte_val = cur_word[23:16];
          3'd2:    byte_val = cur_word[15:8];
          3'd3:    byte_val = cur_word[7:0];
          default: byte_val = 8'd0;  // speed bytes
        endcase
        byte_last = (rd_idx == LAST_COUNTER) && (rd_pos == BLOCK_LAST_POS);
      end
      default: begin
        byte_val  = 8'd0;
        byte_last = 1'b1;
      end
    endcase
  end

  // Read sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_active <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      if (emit) begin
        rsp_valid <= 1'b1;
        if (byte_last) begin
          rd_active <= 1'b0;
        end else if (rd_op == CMD_READ_COUNTERS && rd_pos == BLOCK_LAST_POS) begin
          rd_pos <= '0;
          rd_idx <= rd_idx + 1'b1;
        end else begin
          rd_pos <= rd_pos + 1'b1;
        end
      end
      if (cmd_pop && cmd.op != CMD_COUNT_UP && cmd.op != CMD_COUNT_DOWN) begin
        rd_active <= 1'b1;
        rd_op     <= cmd.op;
        rd_idx    <= cmd.idx;
        rd_pos    <= '0;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.data_byte <= byte_val;
      rsp.last_byte <= byte_last;
    end
  end

  // One counter lane per channel
  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (cmd_pop && cmd.idx == 2'(i)) begin
          if (cmd.op == CMD_COUNT_UP)
            counts[i] <= counts[i] + COUNT_WIDTH'(1);
          else if (cmd.op == CMD_COUNT_DOWN)
            counts[i] <= counts[i] - COUNT_WIDTH'(1);
        end
      end
    end
  end

  // Checks
  a_last_ends_read: assert property (@(posedge clk) disable iff (rst)
    (emit && byte_last) |=> (!rd_active && rsp_valid && rsp.last_byte))
    else $error("read did not end on its last byte");

  a_ppr_len: assert property (@(posedge clk) disable iff (rst)
    (rd_active && rd_op == CMD_READ_PPR) |-> (rd_pos <= 3'd1))
    else $error("ppr read ran past two bytes");

  a_block_pos: assert property (@(posedge clk) disable iff (rst)
    (rd_active && rd_op == CMD_READ_COUNTERS) |-> (rd_pos <= BLOCK_LAST_POS))
    else $error("counter block position out of range");

  a_counts_frozen: assert property (@(posedge clk) disable iff (rst)
    rd_active |=> $stable(counts))
    else $error("counters changed during a read");

endmodule

// ===== hw/rtl/wheel_encoder_tick_counter_unit.sv =====
// Top level of the wheel encoder tick counter: config registers and front/queue/back.
//
// Usage:
//   req channel (req_valid/req_ready/req) takes edge events and register reads.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns read bytes, big-endian, with
//   last_byte set on the final byte of each read.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes count_mode (0),
//   pulses_per_rev (1) and unit_id (2); it is always ready. Write it only
//   while the block is idle.
// Timing:
//   Edge events sustain one item per cycle while the queue has room; the counter
//   changes at the edge where the event leaves the command queue.
//   A read first loads the read sequencer from the command queue, then moves one
//   byte per cycle into the output register while the receiver takes them.
//   The first byte passes the queue and read sequencer to reach the output register.
//   The four-entry command queue keeps accepting items while a read streams.
// Reset clears the counters, the queue and the output valid, and loads
// count_mode 2, pulses_per_rev 2 and unit_id 78.
// When the receiver stalls, the output byte holds, the sequencer waits, and
// input stalls once the queue fills.
module wheel_encoder_tick_counter_unit #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  wetc_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output wetc_pkg::rsp_item_t rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import wetc_pkg::*;

  count_mode_t count_mode;
  report_cfg_t report_cfg;

  logic cmd_in_valid;
  logic cmd_in_ready;
  cmd_t cmd_in;
  logic cmd_out_valid;
  logic cmd_out_ready;
  cmd_t cmd_out;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_mode                <= RESET_MODE;
      report_cfg.pulses_per_rev <= RESET_PPR;
      report_cfg.unit_id        <= RESET_ID;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COUNT_MODE: count_mode                <= count_mode_t'(cfg_data[1:0]);
        CFG_PPR:        report_cfg.pulses_per_rev <= $signed(cfg_data);
        CFG_UNIT_ID:    report_cfg.unit_id        <= cfg_data[7:0];
        default:        ;
      endcase
    end
  end

  wetc_front u_front (
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .count_mode (count_mode),
    .cmd_valid  (cmd_in_valid),
    .cmd_ready  (cmd_in_ready),
    .cmd        (cmd_in)
  );

  wetc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_in_valid),
    .push_ready (cmd_in_ready),
    .push_data  (cmd_in),
    .pop_valid  (cmd_out_valid),
    .pop_ready  (cmd_out_ready),
    .pop_data   (cmd_out)
  );

  wetc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_out_valid),
    .cmd_ready (cmd_out_ready),
    .cmd       (cmd_out),
    .cfg       (report_cfg),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== tb/sv/wheel_encoder_tick_counter_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the wheel encoder tick counter: directed table, then random phases.
module wheel_encoder_tick_counter_unit_test;
  import wetc_pkg::*;

  localparam int COUNT_W     = 32;
  localparam int SETTLE_CYC  = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 40;

  // Encoder channels
  localparam logic [1:0] CH_LEFT_HI  = 2'd0;
  localparam logic [1:0] CH_RIGHT_HI = 2'd1;
  localparam logic [1:0] CH_LEFT_LO  = 2'd2;
  localparam logic [1:0] CH_RIGHT_LO = 2'd3;

  // Register index past the end of the map, writes are dropped
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;

  // Receiver stall patterns
  localparam int STALL_NONE     = 0;
  localparam int STALL_RANDOM   = 1;
  localparam int STALL_PERIODIC = 2;
  localparam int STALL_LONG     = 3;

  typedef struct {
    logic        is_cfg;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_val;
    req_item_t   item;
    int          n_typed;    // -1: expected bytes come from the predictor
    logic [7:0]  typed [6];
  } stim_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_item_t   req       = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_item_t   rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  // Predicted block state
  logic signed [COUNT_W-1:0] enc_cnt [4];
  count_mode_t cur_mode = RESET_MODE;
  logic [15:0] cur_ppr  = RESET_PPR;
  logic [7:0]  cur_id   = RESET_ID;

  rsp_item_t   resp_exp_q [$];
  stim_row_t   dir_tab [$];
  int          err_cnt    = 0;
  int          cycle_cnt  = 0;
  int          burst_left = 0;
  bit          gaps_on    = 1'b1;
  int          stall_mode = STALL_RANDOM;
  int          stall_left = 0;
  logic [7:0]  stall_tick = '0;

  wheel_encoder_tick_counter_unit #(
    .COUNT_WIDTH(COUNT_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    err_cnt++;
    $display("ERROR t=%0t %s", $time, what);
  endtask

  // Counter update for an edge, byte run for a read
  function automatic void predict_item(input req_item_t it, ref rsp_item_t out[$]);
    logic [31:0] w;
    out.delete();
    if (it.func == FUNC_EDGE) begin
      if (it.channel == CH_LEFT_HI || it.channel == CH_RIGHT_HI) begin
        if (cur_mode == MODE_QUADRATURE && !it.partner_level)
          enc_cnt[it.channel] = enc_cnt[it.channel] - 1;
        else
          enc_cnt[it.channel] = enc_cnt[it.channel] + 1;
      end else if (cur_mode != MODE_QUADRATURE) begin
        enc_cnt[it.channel] = enc_cnt[it.channel] + 1;
      end
      return;
    end
    if (it.reg_addr == REG_ID) begin
      out.push_back('{data_byte: cur_id, last_byte: 1'b0});
    end else if (it.reg_addr >= REG_CNT_FIRST && it.reg_addr <= REG_CNT_LAST) begin
      // one six-byte block per counter from the addressed one to the last
      for (int i = int'(it.reg_addr) - 1; i < 4; i++) begin
        w = 32'(enc_cnt[i]);
        out.push_back('{data_byte: w[31:24], last_byte: 1'b0});
        out.push_back('{data_byte: w[23:16], last_byte: 1'b0});
        out.push_back('{data_byte: w[15:8],  last_byte: 1'b0});
        out.push_back('{data_byte: w[7:0],   last_byte: 1'b0});
        out.push_back('{data_byte: 8'h00,    last_byte: 1'b0});
        out.push_back('{data_byte: 8'h00,    last_byte: 1'b0});
      end
    end else if (it.reg_addr == REG_PPR) begin
      out.push_back('{data_byte: cur_ppr[15:8], last_byte: 1'b0});
      out.push_back('{data_byte: cur_ppr[7:0],  last_byte: 1'b0});
    end
    if (out.size() > 0) out[out.size() - 1].last_byte = 1'b1;
  endfunction

  // Sender: bursts of random length, random gaps between them when gaps_on is set
  task automatic send_item(req_item_t it, int n_typed, logic [7:0] typed [6]);
    rsp_item_t got [$];
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gaps_on && gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    req       <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    burst_left--;
    predict_item(it, got);
    if (n_typed >= 0) begin
      got.delete();
      for (int k = 0; k < n_typed; k++)
        got.push_back('{data_byte: typed[k], last_byte: (k == n_typed - 1)});
    end
    foreach (got[k]) resp_exp_q.push_back(got[k]);
  endtask

  // Drop valid, wait out every expected byte and any edges still in flight
  task automatic settle();
    req_valid <= 1'b0;
    while (resp_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_COUNT_MODE: cur_mode = count_mode_t'(val[1:0]);
      CFG_PPR:        cur_ppr  = val;
      CFG_UNIT_ID:    cur_id   = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Directed table builders
  function automatic stim_row_t blank_row();
    stim_row_t r;
    r.is_cfg  = 1'b0;
    r.cfg_idx = '0;
    r.cfg_val = '0;
    r.item    = '0;
    r.n_typed = -1;
    foreach (r.typed[k]) r.typed[k] = '0;
    return r;
  endfunction

  function automatic void add_edge(logic [1:0] ch, logic lvl);
    stim_row_t r;
    r = blank_row();
    r.item.func          = FUNC_EDGE;
    r.item.channel       = ch;
    r.item.partner_level = lvl;
    r.item.reg_addr      = 8'($urandom);
    dir_tab.push_back(r);
  endfunction

  function automatic void add_read(logic [7:0] addr, int n, logic [7:0] b0, logic [7:0] b1);
    stim_row_t r;
    r = blank_row();
    r.item.func          = FUNC_READ;
    r.item.channel       = 2'($urandom);
    r.item.partner_level = 1'($urandom);
    r.item.reg_addr      = addr;
    r.n_typed            = n;
    r.typed[0]           = b0;
    r.typed[1]           = b1;
    dir_tab.push_back(r);
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [15:0] val);
    stim_row_t r;
    r = blank_row();
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    dir_tab.push_back(r);
  endfunction

  function automatic void build_directed_table();
    // reset values, unknown registers
    add_read(REG_ID, 1, 8'd78, 8'h00);
    add_read(REG_PPR, 2, 8'h00, 8'h02);
    add_read(REG_CNT_LAST, 6, 8'h00, 8'h00);
    add_read(8'd6, 0, 8'h00, 8'h00);
    add_read(8'hFF, 0, 8'h00, 8'h00);
    // four-wire: every edge counts up
    add_edge(CH_LEFT_HI, 1'b0);
    add_edge(CH_RIGHT_HI, 1'b1);
    add_edge(CH_LEFT_LO, 1'b0);
    add_edge(CH_RIGHT_LO, 1'b1);
    add_read(REG_CNT_FIRST, -1, 8'h00, 8'h00);
    // quadrature, most negative ppr, largest id
    add_cfg(CFG_COUNT_MODE, {14'h3FFF, MODE_QUADRATURE});
    add_cfg(CFG_PPR, 16'h8000);
    add_cfg(CFG_UNIT_ID, 16'hA5FF);
    add_read(REG_PPR, 2, 8'h80, 8'h00);
    add_read(REG_ID, 1, 8'hFF, 8'h00);
    add_edge(CH_LEFT_HI, 1'b0);
    add_edge(CH_LEFT_HI, 1'b0);    // wraps below zero
    add_edge(CH_RIGHT_HI, 1'b0);
    add_edge(CH_RIGHT_HI, 1'b1);
    add_edge(CH_LEFT_LO, 1'b1);    // low channels ignored here
    add_edge(CH_RIGHT_LO, 1'b0);
    add_read(8'd2, -1, 8'h00, 8'h00);
    // two-wire low, largest ppr, zero id, write past the map
    add_cfg(CFG_COUNT_MODE, {14'h0000, MODE_TWO_WIRE_LOW});
    add_cfg(CFG_PPR, 16'h7FFF);
    add_cfg(CFG_UNIT_ID, 16'h0000);
    add_cfg(CFG_UNMAPPED, 16'hFFFF);
    add_read(REG_PPR, 2, 8'h7F, 8'hFF);
    add_read(REG_ID, 1, 8'h00, 8'h00);
    add_edge(CH_RIGHT_LO, 1'b0);
    add_edge(CH_RIGHT_HI, 1'b0);
    // two-wire high
    add_cfg(CFG_COUNT_MODE, {14'h1555, MODE_TWO_WIRE_HIGH});
    add_edge(CH_LEFT_HI, 1'b0);
    add_read(8'd3, -1, 8'h00, 8'h00);
    add_read(REG_CNT_FIRST, -1, 8'h00, 8'h00);
  endfunction

  // Receiver stall patterns
  always @(posedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    case (stall_mode)
      STALL_NONE:     rsp_ready <= 1'b1;
      STALL_RANDOM:   rsp_ready <= ($urandom_range(3) != 0);
      STALL_PERIODIC: rsp_ready <= (stall_tick[2:0] < 3'd5);
      STALL_LONG: begin
        if (stall_left > 0) begin
          stall_left <= stall_left - 1;
          rsp_ready  <= 1'b0;
        end else if ($urandom_range(9) == 0) begin
          stall_left <= $urandom_range(5, 20);
          rsp_ready  <= 1'b0;
        end else begin
          rsp_ready <= 1'b1;
        end
      end
      default: rsp_ready <= 1'b1;
    endcase
  end

  // Response checker and run limit
  always @(posedge clk) begin
    rsp_item_t exp_byte;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (!rst && rsp_valid && rsp_ready) begin
      if (resp_exp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", rsp.data_byte,
                                  rsp.last_byte));
      end else begin
        exp_byte = resp_exp_q.pop_front();
        if (rsp.data_byte !== exp_byte.data_byte)
          report_mismatch($sformatf("data_byte %02h, expected %02h", rsp.data_byte,
                                    exp_byte.data_byte));
        if (rsp.last_byte !== exp_byte.last_byte)
          report_mismatch($sformatf("last_byte %0b, expected %0b (data %02h)",
                                    rsp.last_byte, exp_byte.last_byte, exp_byte.data_byte));
      end
    end
  end

  // Stimulus
  initial begin
    req_item_t   it;
    logic [7:0]  no_typed [6];
    logic [15:0] rnd16;
    foreach (no_typed[k]) no_typed[k] = '0;
    foreach (enc_cnt[k]) enc_cnt[k] = '0;
    build_directed_table();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (dir_tab[r]) begin
      if (dir_tab[r].is_cfg) begin
        settle();
        write_cfg(dir_tab[r].cfg_idx, dir_tab[r].cfg_val);
      end else begin
        send_item(dir_tab[r].item, dir_tab[r].n_typed, dir_tab[r].typed);
      end
    end

    // random phases, each with its own mode, settings and idling
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      stall_mode <= p % 4;
      gaps_on = (p % 3 != 0);
      rnd16 = 16'($urandom);
      write_cfg(CFG_COUNT_MODE, {rnd16[15:2], 2'(p % 4)});
      rnd16 = 16'($urandom);
      if (p == 1)      write_cfg(CFG_PPR, 16'h8000);
      else if (p == 2) write_cfg(CFG_PPR, 16'h7FFF);
      else             write_cfg(CFG_PPR, rnd16);
      rnd16 = 16'($urandom);
      if (p == 1)      write_cfg(CFG_UNIT_ID, {rnd16[15:8], 8'h00});
      else if (p == 2) write_cfg(CFG_UNIT_ID, {rnd16[15:8], 8'hFF});
      else             write_cfg(CFG_UNIT_ID, rnd16);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.func          = ($urandom_range(99) < 35) ? FUNC_READ : FUNC_EDGE;
        it.channel       = 2'($urandom);
        it.partner_level = 1'($urandom);
        it.reg_addr      = 8'($urandom);
        if (it.func == FUNC_READ && $urandom_range(99) < 85)
          it.reg_addr = 8'($urandom_range(int'(REG_PPR)));
        send_item(it, -1, no_typed);
      end
    end

    settle();
    if (err_cnt == 0 && resp_exp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
